// ----- hw/rtl/tvsmb_pkg.sv -----
// Shared constants, types and helper functions for the TV stripe mask blur core.
package tvsmb_pkg;

    // Pixel component width and full-scale value
    localparam int unsigned PIXEL_BITS = 16;
    localparam int unsigned PIX_MAX    = (1 << PIXEL_BITS) - 1;

    // Noise gain: percent, saturating
    localparam int unsigned STRENGTH_W   = 7;
    localparam int unsigned STRENGTH_MAX = 100;
    localparam int unsigned STRENGTH_RST = 20;

    // Noise scale: noise * strength * PIX_MAX / (16384 * 100) = .../(2^16 * 25)
    localparam int unsigned COEF_W       = 23;            // strength * PIX_MAX
    localparam int unsigned PROD1_W      = 40;            // signed noise * coef
    localparam int unsigned DIV_SHIFT    = 16;            // power-of-two part of divisor
    localparam int unsigned Q_W          = PROD1_W - DIV_SHIFT;
    localparam int unsigned DIV25_BIAS   = 1 << 18;       // keeps dividend positive
    localparam int unsigned DIV25_OFFSET = 25 * DIV25_BIAS;
    localparam int unsigned RECIP25_SH   = 29;
    localparam int unsigned RECIP25      = 21474837;      // ceil(2^29 / 25)
    localparam int unsigned RECIP25_W    = 25;
    localparam int unsigned PROD2_W      = Q_W + RECIP25_W;
    localparam int unsigned ADD_W        = PROD2_W - RECIP25_SH;

    // Masked channel value and filter sum
    localparam int unsigned MASK_W     = 19;
    localparam int unsigned SUM_W      = MASK_W + 2;
    localparam int unsigned HALF_W     = SUM_W - 1;
    localparam int unsigned RECIP3_SH  = 21;
    localparam int unsigned RECIP3     = 699051;          // ceil(2^21 / 3)
    localparam int unsigned PROD3_W    = 2 * HALF_W;

    // Output queue
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_IGNORE_BG      = 1'b0,
        CFG_NOISE_STRENGTH = 1'b1
    } cfg_idx_t;

    // One RGB pixel, red in the low bits
    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } rgb_t;

    // Per-item control carried down the pipeline
    typedef struct packed {
        logic       has_held;   // a pixel was held: emits it with this one as right
        logic       has_left;   // the held pixel has a left neighbor
        logic       row_end;    // this pixel closes the row
        logic       bg;         // background pixel
        logic [1:0] phase;      // column phase of this pixel
    } ctl_t;

    // floor(sum / 6) clamped to full scale: halve, then multiply by reciprocal of 3
    function automatic logic [15:0] filter_out(input logic [SUM_W-1:0] sum);
        logic [HALF_W-1:0]  half;
        logic [PROD3_W-1:0] prod;
        logic [MASK_W-1:0]  quo;
        half = sum[SUM_W-1:1];
        prod = PROD3_W'(half) * PROD3_W'(RECIP3);
        quo  = prod[RECIP3_SH +: MASK_W];
        if (quo > MASK_W'(PIX_MAX)) begin
            filter_out = 16'(PIX_MAX);
        end else begin
            filter_out = quo[15:0];
        end
    endfunction

endpackage

// ----- hw/rtl/tv_stripe_mask_blur_core.sv -----
// TV stripe mask blur: phosphor-mask imitation with a 3-tap horizontal filter.
//
// Pixels arrive one per transaction on the s_ channel, row by row, with
// s_tlast on the last pixel of a row. A column phase 0..3 keeps only red,
// green or blue (tripled, plus scaled noise, floored at 0) or gives black,
// and each channel is filtered as floor((4*center + left + right) / 6) with
// zeros outside the row, then clamped. Background pixels pass unchanged when
// ignore_background is set. Each pixel's result leaves when its right
// neighbor arrives; the row's last pixel also releases its own result. The
// core accepts one pixel per clock while s_tready is high; a released result
// passes four pipeline registers and the output queue before it reaches m_.
// The m_ channel moves one result per clock while m_tready is high, so the
// row-end pair leaves as two transfers; an 8-entry output queue absorbs that
// and any downstream stall, and s_tready drops only while the queue and
// pipeline hold results for eight released transactions. Configuration
// writes must be made while the core is idle.
module tv_stripe_mask_blur_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // red_in, green_in, blue_in, noise
    input  logic        s_tlast,   // row_end
    input  logic [0:0]  s_tuser,   // is_background
    // result pixel stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // red_out, green_out, blue_out
    output logic        m_tlast,   // last_of_row
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [6:0]  cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    logic                                  ignore_bg_reg;
    logic [tvsmb_pkg::STRENGTH_W-1:0]      strength_reg;
    logic [tvsmb_pkg::STRENGTH_W-1:0]      strength_sat;
    logic [tvsmb_pkg::COEF_W-1:0]          coef;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignore_bg_reg <= 1'b1;
            strength_reg  <= tvsmb_pkg::STRENGTH_W'(tvsmb_pkg::STRENGTH_RST);
        end else if (cfg_wr_en) begin
            unique case (tvsmb_pkg::cfg_idx_t'(cfg_addr))
                tvsmb_pkg::CFG_IGNORE_BG:      ignore_bg_reg <= cfg_wdata[0];
                tvsmb_pkg::CFG_NOISE_STRENGTH: strength_reg  <= cfg_wdata;
            endcase
        end
    end

    // saturated gain times full scale
    assign strength_sat = (strength_reg > tvsmb_pkg::STRENGTH_W'(tvsmb_pkg::STRENGTH_MAX))
                        ? tvsmb_pkg::STRENGTH_W'(tvsmb_pkg::STRENGTH_MAX) : strength_reg;
    assign coef = tvsmb_pkg::COEF_W'(strength_sat) * tvsmb_pkg::COEF_W'(tvsmb_pkg::PIX_MAX);

    // ------------------------------------------------------------------
    // Input acceptance and row tracking
    logic                      s_acc;
    logic                      ent_inc;
    logic                      ent_pop;
    logic                      push;
    logic [tvsmb_pkg::CNT_W-1:0] reserved_reg;
    logic                      held_valid_reg;
    logic                      left_valid_reg;
    logic [1:0]                phase_reg;

    assign s_tready = (reserved_reg < tvsmb_pkg::CNT_W'(tvsmb_pkg::FIFO_DEPTH));
    assign s_acc    = s_tvalid && s_tready;
    // a transaction releases a queue entry when a pixel is held or the row ends
    assign ent_inc  = s_acc && (held_valid_reg || s_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            left_valid_reg <= 1'b0;
            phase_reg      <= 2'd0;
            reserved_reg   <= '0;
        end else begin
            if (s_acc) begin
                if (s_tlast) begin
                    held_valid_reg <= 1'b0;
                    left_valid_reg <= 1'b0;
                    phase_reg      <= 2'd0;
                end else begin
                    held_valid_reg <= 1'b1;
                    left_valid_reg <= held_valid_reg;
                    phase_reg      <= phase_reg + 2'd1;
                end
            end
            reserved_reg <= reserved_reg + tvsmb_pkg::CNT_W'(ent_inc)
                                         - tvsmb_pkg::CNT_W'(ent_pop);
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input register
    logic              s0_valid_reg;
    tvsmb_pkg::ctl_t   s0_ctl_reg;
    logic [15:0]       s0_orig_reg [3];
    logic [15:0]       s0_noise_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else begin
            s0_valid_reg <= s_acc;
        end
        if (s_acc) begin
            s0_ctl_reg.has_held <= held_valid_reg;
            s0_ctl_reg.has_left <= left_valid_reg;
            s0_ctl_reg.row_end  <= s_tlast;
            s0_ctl_reg.bg       <= s_tuser[0];
            s0_ctl_reg.phase    <= phase_reg;
            s0_orig_reg[0]      <= s_tdata[15:0]  & 16'(tvsmb_pkg::PIX_MAX);
            s0_orig_reg[1]      <= s_tdata[31:16] & 16'(tvsmb_pkg::PIX_MAX);
            s0_orig_reg[2]      <= s_tdata[47:32] & 16'(tvsmb_pkg::PIX_MAX);
            s0_noise_reg        <= s_tdata[63:48];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: noise times gain
    logic                                s1_valid_reg;
    tvsmb_pkg::ctl_t                     s1_ctl_reg;
    logic [15:0]                         s1_orig_reg [3];
    logic signed [tvsmb_pkg::PROD1_W-1:0] s1_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s0_valid_reg;
        end
        s1_ctl_reg  <= s0_ctl_reg;
        s1_orig_reg <= s0_orig_reg;
        s1_prod_reg <= tvsmb_pkg::PROD1_W'($signed(s0_noise_reg))
                     * tvsmb_pkg::PROD1_W'($signed({1'b0, coef}));
    end

    // ------------------------------------------------------------------
    // Stage 2: floor divide by 2^16 (bit select), then by 25 via reciprocal
    logic                          s2_valid_reg;
    tvsmb_pkg::ctl_t               s2_ctl_reg;
    logic [15:0]                   s2_orig_reg [3];
    logic [tvsmb_pkg::PROD2_W-1:0] s2_prod_reg;
    logic [tvsmb_pkg::Q_W-1:0]     div_in;

    assign div_in = s1_prod_reg[tvsmb_pkg::PROD1_W-1:tvsmb_pkg::DIV_SHIFT]
                  + tvsmb_pkg::Q_W'(tvsmb_pkg::DIV25_OFFSET);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
        s2_ctl_reg  <= s1_ctl_reg;
        s2_orig_reg <= s1_orig_reg;
        s2_prod_reg <= tvsmb_pkg::PROD2_W'(div_in) * tvsmb_pkg::PROD2_W'(tvsmb_pkg::RECIP25);
    end

    // ------------------------------------------------------------------
    // Stage 3: mask the channel, update the neighbor window, form filter sums
    logic [tvsmb_pkg::ADD_W-1:0]         quo25;
    logic signed [tvsmb_pkg::ADD_W-1:0]  noise_add;
    logic signed [tvsmb_pkg::ADD_W-1:0]  chan_sum;
    logic [15:0]                         chan_sel;
    logic [tvsmb_pkg::MASK_W-1:0]        chan_masked;
    logic [tvsmb_pkg::MASK_W-1:0]        masked [3];
    logic [tvsmb_pkg::MASK_W-1:0]        held_masked_reg [3];
    logic [tvsmb_pkg::MASK_W-1:0]        left_masked_reg [3];
    logic [15:0]                         held_orig_reg [3];
    logic                                held_bg_reg;
    logic                                s4_valid_reg;
    logic                                s4_r1v_reg;
    logic                                s4_r2v_reg;
    logic [tvsmb_pkg::SUM_W-1:0]         s4_sum1_reg [3];
    logic [tvsmb_pkg::SUM_W-1:0]         s4_sum2_reg [3];
    logic [15:0]                         s4_orig1_reg [3];
    logic [15:0]                         s4_orig2_reg [3];
    logic                                s4_bg1_reg;
    logic                                s4_bg2_reg;

    assign quo25     = s2_prod_reg[tvsmb_pkg::RECIP25_SH +: tvsmb_pkg::ADD_W];
    assign noise_add = $signed(quo25 - tvsmb_pkg::ADD_W'(tvsmb_pkg::DIV25_BIAS));

    // active channel by column phase
    always_comb begin
        unique case (s2_ctl_reg.phase)
            2'd0:    chan_sel = s2_orig_reg[0];
            2'd1:    chan_sel = s2_orig_reg[1];
            2'd2:    chan_sel = s2_orig_reg[2];
            default: chan_sel = 16'd0;
        endcase
    end

    assign chan_sum    = $signed(tvsmb_pkg::ADD_W'(chan_sel) * tvsmb_pkg::ADD_W'(3)) + noise_add;
    assign chan_masked = chan_sum[tvsmb_pkg::ADD_W-1] ? '0 : chan_sum[tvsmb_pkg::MASK_W-1:0];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            masked[j] = (s2_ctl_reg.phase == 2'(j)) ? chan_masked : '0;
        end
    end

    // window store and sums for the held pixel (first) and the row-end pixel (second)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else begin
            s4_valid_reg <= s2_valid_reg && (s2_ctl_reg.has_held || s2_ctl_reg.row_end);
        end
        if (s2_valid_reg) begin
            if (s2_ctl_reg.has_held) begin
                left_masked_reg <= held_masked_reg;
            end
            held_masked_reg <= masked;
            held_orig_reg   <= s2_orig_reg;
            held_bg_reg     <= s2_ctl_reg.bg;
        end
        s4_r1v_reg   <= s2_ctl_reg.has_held;
        s4_r2v_reg   <= s2_ctl_reg.row_end;
        s4_orig1_reg <= held_orig_reg;
        s4_orig2_reg <= s2_orig_reg;
        s4_bg1_reg   <= held_bg_reg;
        s4_bg2_reg   <= s2_ctl_reg.bg;
        for (int j = 0; j < 3; j++) begin
            s4_sum1_reg[j] <= (tvsmb_pkg::SUM_W'(held_masked_reg[j]) << 2)
                            + (s2_ctl_reg.has_left ? tvsmb_pkg::SUM_W'(left_masked_reg[j]) : '0)
                            + tvsmb_pkg::SUM_W'(masked[j]);
            s4_sum2_reg[j] <= (tvsmb_pkg::SUM_W'(masked[j]) << 2)
                            + (s2_ctl_reg.has_held ? tvsmb_pkg::SUM_W'(held_masked_reg[j]) : '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: divide by 6, clamp, background bypass; write the output queue
    tvsmb_pkg::rgb_t res1;
    tvsmb_pkg::rgb_t res2;
    tvsmb_pkg::rgb_t orig1;
    tvsmb_pkg::rgb_t orig2;
    tvsmb_pkg::rgb_t filt1;
    tvsmb_pkg::rgb_t filt2;

    assign filt1.red   = tvsmb_pkg::filter_out(s4_sum1_reg[0]);
    assign filt1.green = tvsmb_pkg::filter_out(s4_sum1_reg[1]);
    assign filt1.blue  = tvsmb_pkg::filter_out(s4_sum1_reg[2]);
    assign filt2.red   = tvsmb_pkg::filter_out(s4_sum2_reg[0]);
    assign filt2.green = tvsmb_pkg::filter_out(s4_sum2_reg[1]);
    assign filt2.blue  = tvsmb_pkg::filter_out(s4_sum2_reg[2]);
    assign orig1       = '{blue: s4_orig1_reg[2], green: s4_orig1_reg[1], red: s4_orig1_reg[0]};
    assign orig2       = '{blue: s4_orig2_reg[2], green: s4_orig2_reg[1], red: s4_orig2_reg[0]};
    assign res1        = (ignore_bg_reg && s4_bg1_reg) ? orig1 : filt1;
    assign res2        = (ignore_bg_reg && s4_bg2_reg) ? orig2 : filt2;
    assign push        = s4_valid_reg;

    // ------------------------------------------------------------------
    // Output queue: one entry per releasing transaction, one or two results each
    tvsmb_pkg::rgb_t               fifo_first_reg  [tvsmb_pkg::FIFO_DEPTH];
    tvsmb_pkg::rgb_t               fifo_second_reg [tvsmb_pkg::FIFO_DEPTH];
    logic                          fifo_two_reg    [tvsmb_pkg::FIFO_DEPTH];
    logic                          fifo_last_reg   [tvsmb_pkg::FIFO_DEPTH];
    logic [tvsmb_pkg::PTR_W-1:0]   wr_ptr_reg;
    logic [tvsmb_pkg::PTR_W-1:0]   rd_ptr_reg;
    logic [tvsmb_pkg::CNT_W-1:0]   fifo_cnt_reg;
    logic                          sub_reg;
    logic                          head_two;
    logic                          m_acc;

    assign head_two = fifo_two_reg[rd_ptr_reg];
    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = sub_reg ? fifo_second_reg[rd_ptr_reg] : fifo_first_reg[rd_ptr_reg];
    // the row flag rides on the final result of a row-end entry only
    assign m_tlast  = fifo_last_reg[rd_ptr_reg] && (!head_two || sub_reg);
    assign m_acc    = m_tvalid && m_tready;
    assign ent_pop  = m_acc && (!head_two || sub_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            sub_reg      <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + tvsmb_pkg::PTR_W'(1);
            end
            if (m_acc) begin
                if (ent_pop) begin
                    rd_ptr_reg <= rd_ptr_reg + tvsmb_pkg::PTR_W'(1);
                    sub_reg    <= 1'b0;
                end else begin
                    sub_reg    <= 1'b1;
                end
            end
            fifo_cnt_reg <= fifo_cnt_reg + tvsmb_pkg::CNT_W'(push)
                                         - tvsmb_pkg::CNT_W'(ent_pop);
        end
        if (push) begin
            fifo_first_reg[wr_ptr_reg]  <= s4_r1v_reg ? res1 : res2;
            fifo_second_reg[wr_ptr_reg] <= res2;
            fifo_two_reg[wr_ptr_reg]    <= s4_r1v_reg && s4_r2v_reg;
            fifo_last_reg[wr_ptr_reg]   <= s4_r2v_reg;
        end
    end

`ifndef SYNTH
    // queued entries are always covered by the reservation count
    a_cnt_le_reserved: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= reserved_reg)
        else $error("output queue holds more entries than reserved");

    // reservation keeps the queue from overflowing
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_cnt_reg < tvsmb_pkg::CNT_W'(tvsmb_pkg::FIFO_DEPTH)))
        else $error("write into a full output queue");

    // second half of an entry is only selected on a two-result entry
    a_sub_two: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg |-> (m_tvalid && head_two))
        else $error("second result selected on a single-result entry");

    // a row end clears the window and restarts the phase
    a_row_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> (!held_valid_reg && !left_valid_reg && phase_reg == 2'd0))
        else $error("row end did not restart the row");
`endif

endmodule
